// ===== src/ipsl_pkg.sv =====
// Shared types and constants for the incremental PID speed loop.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ipsl_pkg;

  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 15;
  localparam int DRIVE_W    = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT = 8'd3;

  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = 16'd256;
  localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST  = 16'd1280;
  localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST  = 16'd2560;
  localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST = 15'd2000;

  typedef struct packed {
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  integ_gain;
    logic [GAIN_W-1:0]  deriv_gain;
    logic [LIMIT_W-1:0] drive_limit;
  } cfg_t;

endpackage

`default_nettype wire

// ===== src/ipsl_cfg_regs.sv =====
// Configuration register bank: gains and drive limit.
// Depends on ipsl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipsl_cfg_regs
  import ipsl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain   <= PROP_GAIN_RST;
      cfg.integ_gain  <= INTEG_GAIN_RST;
      cfg.deriv_gain  <= DERIV_GAIN_RST;
      cfg.drive_limit <= DRIVE_LIMIT_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_PROP_GAIN:   cfg.prop_gain   <= wr_data[GAIN_W-1:0];
        REG_INTEG_GAIN:  cfg.integ_gain  <= wr_data[GAIN_W-1:0];
        REG_DERIV_GAIN:  cfg.deriv_gain  <= wr_data[GAIN_W-1:0];
        REG_DRIVE_LIMIT: cfg.drive_limit <= wr_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/ipsl_err_mult.sv =====
// Error stage: forms the error, keeps the two-deep error history and
// registers the three gain products. Depends on ipsl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipsl_err_mult
  import ipsl_pkg::*;
#(
  parameter int SPEED_BITS = 16,
  localparam int ERR_W  = SPEED_BITS + 1,
  localparam int D2_W   = SPEED_BITS + 3,
  localparam int PROD_W = GAIN_W + D2_W + 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire cfg_t                         cfg,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [SPEED_BITS-1:0] target_speed,
  input  wire logic signed [SPEED_BITS-1:0] measured_speed,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [PROD_W-1:0]          prod_p,
  output logic signed [PROD_W-1:0]          prod_i,
  output logic signed [PROD_W-1:0]          prod_d
);

  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W-1:0]  err_last;
  logic signed [ERR_W-1:0]  err_prev;
  logic signed [D2_W-1:0]   d1;
  logic signed [D2_W-1:0]   d2;
  logic signed [D2_W-1:0]   e_ext;
  logic signed [PROD_W-1:0] prod_p_next;
  logic signed [PROD_W-1:0] prod_i_next;
  logic signed [PROD_W-1:0] prod_d_next;
  logic                     adv;
  logic                     err_zero;

  assign in_ready = !out_valid || out_ready;
  assign adv      = in_valid && in_ready;

  assign err      = ERR_W'(target_speed) - ERR_W'(measured_speed);
  assign err_zero = (err == '0);
  assign e_ext    = D2_W'(err);
  assign d1       = e_ext - D2_W'(err_last);
  assign d2       = e_ext - (D2_W'(err_last) <<< 1) + D2_W'(err_prev);

  assign prod_p_next = err_zero ? '0 :
    PROD_W'($signed({1'b0, cfg.prop_gain})) * PROD_W'(d1);
  assign prod_i_next = err_zero ? '0 :
    PROD_W'($signed({1'b0, cfg.integ_gain})) * PROD_W'(e_ext);
  assign prod_d_next = err_zero ? '0 :
    PROD_W'($signed({1'b0, cfg.deriv_gain})) * PROD_W'(d2);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      err_last  <= '0;
      err_prev  <= '0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (adv) begin
        err_last <= err;
        err_prev <= err_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_p <= prod_p_next;
      prod_i <= prod_i_next;
      prod_d <= prod_d_next;
    end
  end

  a_zero_err_no_inc: assert property (@(posedge clk) disable iff (rst)
    (adv && err_zero) |=> (prod_p == '0 && prod_i == '0 && prod_d == '0))
    else $error("zero error produced a nonzero increment");

  a_history_shift: assert property (@(posedge clk) disable iff (rst)
    adv |=> (err_prev == $past(err_last)))
    else $error("error history did not shift");

endmodule

`default_nettype wire

// ===== src/ipsl_accum.sv =====
// Accumulate stage: adds the increment, clamps to the drive limit and
// registers the truncated drive beat. Depends on ipsl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipsl_accum
  import ipsl_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = 8,
  parameter int PROD_W         = 36,
  localparam int ACC_W = LIMIT_W + GAIN_FRAC_BITS + 2,
  localparam int SUM_W = ((PROD_W + 2 > ACC_W) ? PROD_W + 2 : ACC_W) + 1
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cfg_t                     cfg,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [PROD_W-1:0] prod_p,
  input  wire logic signed [PROD_W-1:0] prod_i,
  input  wire logic signed [PROD_W-1:0] prod_d,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [DRIVE_W-1:0]     drive_value
);

  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_next;
  logic signed [SUM_W-1:0]   total;
  logic signed [SUM_W-1:0]   bound;
  logic signed [ACC_W-1:0]   mag_full;
  logic [DRIVE_W-2:0]        mag;
  logic signed [DRIVE_W-1:0] drive_next;
  logic                      adv;

  assign in_ready = !out_valid || out_ready;
  assign adv      = in_valid && in_ready;

  assign bound = SUM_W'(cfg.drive_limit) <<< GAIN_FRAC_BITS;
  assign total = SUM_W'(acc) + SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);

  always_comb begin
    if (total > bound) begin
      acc_next = ACC_W'(bound);
    end else if (total < -bound) begin
      acc_next = ACC_W'(-bound);
    end else begin
      acc_next = ACC_W'(total);
    end
  end

  assign mag_full   = acc_next[ACC_W-1] ? -acc_next : acc_next;
  assign mag        = mag_full[GAIN_FRAC_BITS +: (DRIVE_W - 1)];
  assign drive_next = acc_next[ACC_W-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      acc       <= '0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (adv) begin
        acc <= acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      drive_value <= drive_next;
    end
  end

  a_acc_in_bound: assert property (@(posedge clk) disable iff (rst)
    adv |=> (SUM_W'(acc) <= $past(bound) && SUM_W'(acc) >= -$past(bound)))
    else $error("accumulator outside drive limit after update");

  a_beat_follows: assert property (@(posedge clk) disable iff (rst)
    adv |=> out_valid)
    else $error("accepted item produced no drive beat");

endmodule

`default_nettype wire

// ===== src/incremental_pid_speed_loop.sv =====
// Top level of the incremental PID speed loop: input register, config bank,
// error/multiply stage and accumulate stage. Depends on ipsl_pkg and submodules.
//
//  port group  dir  beat contents
//  s_*         in   tdata: target_speed, measured_speed (SPEED_BITS each)
//  m_*         out  tdata: drive_value (16 bits)
//  cfg_*       in   cfg_index, cfg_data: register write
//
// Three register stages (input, products, accumulator/drive); one item per cycle
// sustained while m_tready is high; the accumulator add-and-clamp loop sets the rate.
// Synchronous reset clears valids, error history and accumulator, restores gains and drive limit.
// A stall on m_tready fills the stages one by one; s_tready drops only when all
// three are full. cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module incremental_pid_speed_loop
  import ipsl_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = 8,
  parameter int SPEED_BITS     = 16,
  localparam int IN_W   = ((2 * SPEED_BITS + 7) / 8) * 8,
  localparam int PROD_W = GAIN_W + SPEED_BITS + 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_W-1:0]       s_tdata,   // target_speed, measured_speed, zero pad
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [DRIVE_W-1:0]         m_tdata,   // drive_value
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t                           cfg;
  logic                           in_valid;
  logic signed [SPEED_BITS-1:0]   target_speed;
  logic signed [SPEED_BITS-1:0]   measured_speed;
  logic                           mult_ready;
  logic                           mult_valid;
  logic                           acc_ready;
  logic signed [PROD_W-1:0]       prod_p;
  logic signed [PROD_W-1:0]       prod_i;
  logic signed [PROD_W-1:0]       prod_d;
  logic signed [DRIVE_W-1:0]      drive_value;

  assign cfg_ready = 1'b1;
  assign s_tready  = !in_valid || mult_ready;
  assign m_tdata   = drive_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      target_speed   <= s_tdata[SPEED_BITS-1:0];
      measured_speed <= s_tdata[2*SPEED_BITS-1:SPEED_BITS];
    end
  end

  ipsl_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  ipsl_err_mult #(
    .SPEED_BITS (SPEED_BITS)
  ) u_err_mult (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (mult_ready),
    .target_speed   (target_speed),
    .measured_speed (measured_speed),
    .out_valid      (mult_valid),
    .out_ready      (acc_ready),
    .prod_p         (prod_p),
    .prod_i         (prod_i),
    .prod_d         (prod_d)
  );

  ipsl_accum #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .PROD_W         (PROD_W)
  ) u_accum (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (mult_valid),
    .in_ready    (acc_ready),
    .prod_p      (prod_p),
    .prod_i      (prod_i),
    .prod_d      (prod_d),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .drive_value (drive_value)
  );

  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && mult_valid && m_tvalid && !m_tready))
    else $error("input blocked while a stage is free");

endmodule

`default_nettype wire
